// ===== hdl/isc_pkg.sv =====
package isc_pkg;

    typedef enum logic [2:0] {
        KIND_CHAR     = 3'd0,
        KIND_END_INSTR = 3'd1,
        KIND_END_INPUT = 3'd2,
        KIND_QUIT     = 3'd3,
        KIND_MODE     = 3'd4,
        KIND_RESET    = 3'd5
    } t_kind;

    localparam logic [7:0] CH_TOGGLE    = 8'h02;
    localparam logic [7:0] CH_RESET     = 8'h03;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_EOF       = 8'h1A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_DOLLAR    = 8'h24;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_PRINT_LO  = 8'h20;
    localparam logic [7:0] CH_PRINT_HI  = 8'h7F;

    localparam logic [2:0] QUIT_LEN  = 3'd6;
    localparam logic [2:0] QUIT_DEAD = 3'd7;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_char;
        logic        mode;
        logic [15:0] line_number;
    } t_result;

    typedef struct packed {
        logic [1:0]   count;
        t_result [2:0] res;
    } t_bundle;

    function automatic logic [7:0] quit_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h2A;
            3'd1:    ch = 8'h71;
            3'd2:    ch = 8'h75;
            3'd3:    ch = 8'h69;
            3'd4:    ch = 8'h74;
            3'd5:    ch = 8'h2A;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/isc_front.sv =====
module isc_front #(
    parameter int BUFFER_CHARS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_cmd,
    input  logic [7:0]        i_char_code,
    output isc_pkg::t_bundle  o_bundle
);

    localparam int CW = $clog2(BUFFER_CHARS + 1);
    localparam logic [CW-1:0] CAP_LIMIT = CW'(BUFFER_CHARS - 3);

    logic          r_mode, n_mode;
    logic          r_str, n_str;
    logic          r_esc, n_esc;
    logic          r_cmt, n_cmt;
    logic          r_psp, n_psp;
    logic          r_psc, n_psc;
    logic [CW-1:0] r_cc, n_cc;
    logic [7:0]    r_last, n_last;
    logic [2:0]    r_qp, n_qp;
    logic [15:0]   r_lines, n_lines;
    logic          r_disc, n_disc;

    always_comb begin
        logic [7:0]           ch;
        logic [1:0]           n;
        isc_pkg::t_result [2:0] res;
        logic                 eof, ignored, lead, quit_hit, drop, rspace, rsemi, sep;

        n_mode  = r_mode;
        n_str   = r_str;
        n_esc   = r_esc;
        n_cmt   = r_cmt;
        n_psp   = r_psp;
        n_psc   = r_psc;
        n_cc    = r_cc;
        n_last  = r_last;
        n_qp    = r_qp;
        n_lines = r_lines;
        n_disc  = r_disc;
        ch       = i_char_code;
        n        = 2'd0;
        res      = '0;
        eof      = 1'b0;
        ignored  = 1'b0;
        lead     = 1'b0;
        quit_hit = 1'b0;
        drop     = 1'b0;
        rspace   = 1'b0;
        rsemi    = 1'b0;
        sep      = 1'b0;

        if (i_cmd) begin
            n_disc = 1'b1;
        end else if (ch == isc_pkg::CH_TOGGLE || ch == isc_pkg::CH_RESET) begin
            n_mode  = (ch == isc_pkg::CH_TOGGLE) ? ~r_mode : 1'b0;
            n_cc    = '0;
            n_lines = '0;
            n_qp    = '0;
            n_disc  = 1'b0;
            n_psp   = 1'b0;
            n_psc   = 1'b0;
            n_str   = 1'b0;
            n_esc   = 1'b0;
            n_cmt   = 1'b0;
            res[0].kind = (ch == isc_pkg::CH_TOGGLE) ? isc_pkg::KIND_MODE : isc_pkg::KIND_RESET;
            res[0].mode = n_mode;
            n = 2'd1;
        end else begin
            eof = (!r_mode && ch == isc_pkg::CH_NEWLINE) || ch == isc_pkg::CH_EOF;
            ignored = (ch < isc_pkg::CH_PRINT_LO && ch != isc_pkg::CH_NEWLINE) ||
                      (ch > isc_pkg::CH_PRINT_HI);
            if (eof) begin
                if (r_cc != '0 && r_last != isc_pkg::CH_SEMICOLON) begin
                    res[n].kind     = isc_pkg::KIND_CHAR;
                    res[n].out_char = isc_pkg::CH_SEMICOLON;
                    res[n].mode     = n_mode;
                    n      = n + 2'd1;
                    n_cc   = n_cc + CW'(1);
                    n_last = isc_pkg::CH_SEMICOLON;
                end
                if ((r_str && ch == isc_pkg::CH_NEWLINE) || n_cc != '0) begin
                    res[n].kind = isc_pkg::KIND_END_INSTR;
                    res[n].mode = n_mode;
                    n     = n + 2'd1;
                    n_str = 1'b0;
                    n_esc = 1'b0;
                end
                n_mode = 1'b0;
                res[n].kind        = isc_pkg::KIND_END_INPUT;
                res[n].mode        = 1'b0;
                res[n].line_number = r_lines;
                n       = n + 2'd1;
                n_cc    = '0;
                n_lines = '0;
                n_qp    = '0;
                n_disc  = 1'b0;
            end else if (!ignored && !r_disc) begin
                lead = (r_qp == 3'd0) && (ch == isc_pkg::CH_SPACE);
                if (ch == isc_pkg::CH_NEWLINE) begin
                    if (r_lines != 16'hFFFF) begin
                        n_lines = r_lines + 16'd1;
                    end
                    n_qp = '0;
                end
                if (!r_mode && !lead && ch != isc_pkg::CH_NEWLINE &&
                    n_qp != isc_pkg::QUIT_DEAD) begin
                    if (n_qp < isc_pkg::QUIT_LEN && ch == isc_pkg::quit_char(n_qp)) begin
                        n_qp = n_qp + 3'd1;
                        quit_hit = (n_qp == isc_pkg::QUIT_LEN);
                    end else begin
                        n_qp = isc_pkg::QUIT_DEAD;
                    end
                end
                if (quit_hit) begin
                    res[0].kind = isc_pkg::KIND_QUIT;
                    res[0].mode = r_mode;
                    n = 2'd1;
                end else begin
                    if (r_str) begin
                        if (ch == isc_pkg::CH_BACKSLASH) begin
                            n_esc = ~r_esc;
                        end else if (ch == isc_pkg::CH_QUOTE) begin
                            n_str = r_esc;
                            n_esc = 1'b0;
                        end else begin
                            n_esc = 1'b0;
                        end
                        n_psp = 1'b0;
                        n_psc = 1'b0;
                    end else if (r_cmt) begin
                        if (ch == isc_pkg::CH_NEWLINE) begin
                            n_cmt = 1'b0;
                        end
                        drop = 1'b1;
                    end else if ((ch == isc_pkg::CH_SPACE || ch == isc_pkg::CH_NEWLINE) &&
                                 r_cc == '0) begin
                        drop = 1'b1;
                    end else begin
                        if (ch == isc_pkg::CH_QUOTE) begin
                            n_str = 1'b1;
                        end else if (ch == isc_pkg::CH_DOLLAR) begin
                            n_cmt = 1'b1;
                            drop  = 1'b1;
                        end else if (ch == isc_pkg::CH_NEWLINE) begin
                            ch = isc_pkg::CH_SPACE;
                        end
                        if (!drop) begin
                            rspace = r_cc != '0 && ch == isc_pkg::CH_SPACE && r_psp;
                            rsemi  = ch == isc_pkg::CH_SEMICOLON && r_psc;
                            n_psp  = ch == isc_pkg::CH_SPACE;
                            n_psc  = ch == isc_pkg::CH_SEMICOLON;
                        end
                    end
                    if (!drop) begin
                        if (r_cc <= CAP_LIMIT && !rspace && !rsemi) begin
                            res[n].kind     = isc_pkg::KIND_CHAR;
                            res[n].out_char = ch;
                            res[n].mode     = r_mode;
                            n      = n + 2'd1;
                            n_cc   = r_cc + CW'(1);
                            n_last = ch;
                        end
                        sep = (!n_str && ch == isc_pkg::CH_SEMICOLON && !rsemi) ||
                              (n_str && ch == isc_pkg::CH_NEWLINE);
                        if (sep) begin
                            res[n].kind = isc_pkg::KIND_END_INSTR;
                            res[n].mode = r_mode;
                            n     = n + 2'd1;
                            n_cc  = '0;
                            n_str = 1'b0;
                            n_esc = 1'b0;
                        end
                    end
                end
            end
        end

        o_bundle.count = n;
        o_bundle.res   = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_str   <= 1'b0;
            r_esc   <= 1'b0;
            r_cmt   <= 1'b0;
            r_psp   <= 1'b0;
            r_psc   <= 1'b0;
            r_cc    <= '0;
            r_last  <= '0;
            r_qp    <= '0;
            r_lines <= '0;
            r_disc  <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_str   <= n_str;
            r_esc   <= n_esc;
            r_cmt   <= n_cmt;
            r_psp   <= n_psp;
            r_psc   <= n_psc;
            r_cc    <= n_cc;
            r_last  <= n_last;
            r_qp    <= n_qp;
            r_lines <= n_lines;
            r_disc  <= n_disc;
        end
    end

endmodule

// ===== hdl/isc_queue.sv =====
module isc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  isc_pkg::t_bundle  i_data,
    input  logic              i_pop,
    output isc_pkg::t_bundle  o_data,
    output logic              o_empty,
    output logic              o_full
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    isc_pkg::t_bundle r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (AW+1)'(1);
            end
        end
    end

endmodule

// ===== hdl/isc_back.sv =====
module isc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  isc_pkg::t_bundle  i_bundle,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output isc_pkg::t_result  o_result,
    output logic              o_last
);

    logic             r_valid;
    isc_pkg::t_result r_result;
    logic             r_last;
    logic [1:0]       r_idx;
    logic             load, final_one;

    assign load      = !i_empty && (!r_valid || i_ready);
    assign final_one = (r_idx == i_bundle.count - 2'd1);
    assign o_pop     = load && final_one;

    assign o_valid  = r_valid;
    assign o_result = r_result;
    assign o_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_bundle.res[r_idx];
            r_last   <= final_one;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= final_one ? 2'd0 : r_idx + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/instruction_stream_cleaner.sv =====
// A byte's results pass through the result queue and the output register to the master side.
// Throughput: one byte per cycle on the slave side while the queue is not full; results
// leave one per cycle while the master is ready, so a byte's results go out in turn.
// A four-entry result queue between the classifier and the output stage absorbs bursts.
// Reset is synchronous and active low; it returns the block to immediate mode with an empty
// instruction and an empty queue.
module instruction_stream_cleaner #(
    parameter int BUFFER_CHARS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
    input  logic        s_axis_tuser,  // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [7:0] out_char, [8] mode, [24:9] line_number
    output logic [2:0]  m_axis_tuser,  // [2:0] kind
    output logic        m_axis_tlast
);

    isc_pkg::t_bundle front_bundle, queue_head;
    isc_pkg::t_result result;
    logic             accept, q_empty, q_full, q_pop;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    isc_front #(
        .BUFFER_CHARS(BUFFER_CHARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cmd      (s_axis_tuser),
        .i_char_code(s_axis_tdata),
        .o_bundle   (front_bundle)
    );

    isc_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept && front_bundle.count != 2'd0),
        .i_data (front_bundle),
        .i_pop  (q_pop),
        .o_data (queue_head),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    isc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bundle(queue_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_result(result),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, result.line_number, result.mode, result.out_char};
    assign m_axis_tuser = result.kind;

endmodule
